/* rtl/b2da_pkg.sv */
// Shared constants and helpers for the binary to decimal ASCII converter.
// No dependencies; used by every module under rtl/.
`timescale 1ns / 1ps

package b2da_pkg;

    localparam int IN_BITS          = 32;
    localparam int CHAR_BITS        = 6;
    localparam int DIGIT_BITS       = 4;
    localparam int STEP_BITS        = 4;
    localparam int QUEUE_DEPTH      = 2;
    localparam int VALUE_BITS_DEF   = 32;
    localparam int MAX_DIGITS_DEF   = 10;

    localparam logic [CHAR_BITS-1:0]  ASCII_ZERO  = 6'd48;
    localparam logic [DIGIT_BITS-1:0] DABBLE_MIN  = 4'd5;
    localparam logic [DIGIT_BITS-1:0] DABBLE_ADD  = 4'd3;

    // Shift-add-3 correction of one BCD digit before it is doubled.
    function automatic logic [DIGIT_BITS-1:0] dabble_adjust(input logic [DIGIT_BITS-1:0] d);
        logic [DIGIT_BITS-1:0] r;
        if (d >= DABBLE_MIN)
        begin
            r = d + DABBLE_ADD;
        end
        else
        begin
            r = d;
        end
        return r;
    endfunction

endpackage

/* rtl/b2da_front.sv */
// Front end: masks incoming numbers and holds them in a short queue.
// Depends on b2da_pkg.
`timescale 1ns / 1ps

module b2da_front #(
    parameter int VALUE_BITS = b2da_pkg::VALUE_BITS_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic [b2da_pkg::IN_BITS-1:0] value,
    input  logic                        push,
    output logic                        full,
    output logic                        q_valid,
    output logic [VALUE_BITS-1:0]       q_value,
    input  logic                        q_take
);

    localparam int DEPTH = b2da_pkg::QUEUE_DEPTH;
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [VALUE_BITS-1:0] mem_reg [DEPTH];
    logic [PTR_W-1:0]      wr_ptr_reg;
    logic [PTR_W-1:0]      rd_ptr_reg;
    logic [CNT_W-1:0]      count_reg;
    logic [VALUE_BITS-1:0] masked;
    logic                  wr_en;
    logic                  rd_en;

    assign masked  = VALUE_BITS'(value);
    assign full    = (count_reg == CNT_W'(DEPTH));
    assign q_valid = (count_reg != '0);
    assign q_value = mem_reg[rd_ptr_reg];
    assign wr_en   = push && !full;
    assign rd_en   = q_take && q_valid;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_ptr_reg] <= masked;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (wr_en)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (rd_en)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (wr_en && !rd_en)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (rd_en && !wr_en)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

/* rtl/b2da_conv.sv */
// Converter: double-dabble binary to BCD, STEP_BITS bits per cycle,
// then digit count with overflow handling. Depends on b2da_pkg.
`timescale 1ns / 1ps

module b2da_conv #(
    parameter int VALUE_BITS = b2da_pkg::VALUE_BITS_DEF,
    parameter int MAX_DIGITS = b2da_pkg::MAX_DIGITS_DEF,
    localparam int BCD_W     = MAX_DIGITS * b2da_pkg::DIGIT_BITS,
    localparam int CNT_W     = $clog2(MAX_DIGITS + 1)
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    input  logic [VALUE_BITS-1:0] in_value,
    output logic                  in_take,
    output logic                  out_valid,
    output logic [BCD_W-1:0]      out_digits,
    output logic [CNT_W-1:0]      out_count,
    input  logic                  out_ready
);

    localparam int DW       = b2da_pkg::DIGIT_BITS;
    localparam int SB       = b2da_pkg::STEP_BITS;
    localparam int STEPS    = (VALUE_BITS + SB - 1) / SB;
    localparam int PAD_BITS = STEPS * SB;
    localparam int SC_W     = $clog2(STEPS + 1);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_DONE
    } state_t;

    state_t              state_reg;
    logic [PAD_BITS-1:0] work_reg;
    logic [BCD_W-1:0]    bcd_reg;
    logic                ovf_reg;
    logic [SC_W-1:0]     step_reg;

    logic [PAD_BITS-1:0] work_next;
    logic [BCD_W-1:0]    bcd_next;
    logic                ovf_next;
    logic [CNT_W-1:0]    count;
    logic                load;

    always_comb
    begin
        logic [BCD_W-1:0]    b;
        logic [PAD_BITS-1:0] w;
        logic                o;
        b = bcd_reg;
        w = work_reg;
        o = ovf_reg;
        for (int s = 0; s < SB; s++)
        begin
            for (int d = 0; d < MAX_DIGITS; d++)
            begin
                b[d*DW +: DW] = b2da_pkg::dabble_adjust(b[d*DW +: DW]);
            end
            o = o | b[BCD_W-1];
            b = {b[BCD_W-2:0], w[PAD_BITS-1]};
            w = {w[PAD_BITS-2:0], 1'b0};
        end
        bcd_next  = b;
        work_next = w;
        ovf_next  = o;
    end

    always_comb
    begin
        count = CNT_W'(1);
        for (int d = 0; d < MAX_DIGITS; d++)
        begin
            if (bcd_reg[d*DW +: DW] != '0)
            begin
                count = CNT_W'(d + 1);
            end
        end
        if (ovf_reg)
        begin
            count = CNT_W'(MAX_DIGITS);
        end
    end

    assign out_valid  = (state_reg == ST_DONE);
    assign out_digits = bcd_reg;
    assign out_count  = count;
    assign load       = in_valid && ((state_reg == ST_IDLE) ||
                                     ((state_reg == ST_DONE) && out_ready));
    assign in_take    = load;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            work_reg  <= '0;
            bcd_reg   <= '0;
            ovf_reg   <= 1'b0;
            step_reg  <= '0;
        end
        else
        begin
            case (state_reg)
                ST_IDLE, ST_DONE:
                begin
                    if (load)
                    begin
                        work_reg  <= PAD_BITS'(in_value);
                        bcd_reg   <= '0;
                        ovf_reg   <= 1'b0;
                        step_reg  <= '0;
                        state_reg <= ST_RUN;
                    end
                    else if (state_reg == ST_DONE && out_ready)
                    begin
                        state_reg <= ST_IDLE;
                    end
                end
                ST_RUN:
                begin
                    work_reg <= work_next;
                    bcd_reg  <= bcd_next;
                    ovf_reg  <= ovf_next;
                    step_reg <= step_reg + 1'b1;
                    if (step_reg == SC_W'(STEPS - 1))
                    begin
                        state_reg <= ST_DONE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

endmodule

/* rtl/b2da_emit.sv */
// Back end: holds one number's digits and sends them out most significant
// first through a registered output stage. Depends on b2da_pkg.
`timescale 1ns / 1ps

module b2da_emit #(
    parameter int MAX_DIGITS = b2da_pkg::MAX_DIGITS_DEF,
    localparam int BCD_W     = MAX_DIGITS * b2da_pkg::DIGIT_BITS,
    localparam int CNT_W     = $clog2(MAX_DIGITS + 1)
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    input  logic [BCD_W-1:0]                 in_digits,
    input  logic [CNT_W-1:0]                 in_count,
    output logic                             in_ready,
    output logic [b2da_pkg::CHAR_BITS-1:0]   digit_char,
    output logic                             last,
    output logic                             empty,
    input  logic                             pop
);

    localparam int DW    = b2da_pkg::DIGIT_BITS;
    localparam int IDX_W = $clog2(MAX_DIGITS);

    logic [DW-1:0]                   digit_store_reg [MAX_DIGITS];
    logic                            busy_reg;
    logic [IDX_W-1:0]                idx_reg;
    logic                            out_valid_reg;
    logic [b2da_pkg::CHAR_BITS-1:0]  digit_char_reg;
    logic                            last_reg;
    logic                            take;
    logic                            load;

    assign in_ready   = !busy_reg;
    assign take       = in_valid && !busy_reg;
    assign load       = busy_reg && (!out_valid_reg || pop);
    assign digit_char = digit_char_reg;
    assign last       = last_reg;
    assign empty      = !out_valid_reg;

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            for (int d = 0; d < MAX_DIGITS; d++)
            begin
                digit_store_reg[d] <= in_digits[d*DW +: DW];
            end
        end
        if (load)
        begin
            digit_char_reg <= b2da_pkg::ASCII_ZERO +
                              b2da_pkg::CHAR_BITS'(digit_store_reg[idx_reg]);
            last_reg       <= (idx_reg == '0);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (take)
            begin
                busy_reg <= 1'b1;
                idx_reg  <= IDX_W'(in_count - CNT_W'(1));
            end
            else if (load)
            begin
                if (idx_reg == '0)
                begin
                    busy_reg <= 1'b0;
                end
                else
                begin
                    idx_reg <= idx_reg - 1'b1;
                end
            end
            if (load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (pop)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

endmodule

/* rtl/binary_to_decimal_ascii.sv */
// Top level of the binary to decimal ASCII converter.
// Depends on b2da_pkg, b2da_front, b2da_conv and b2da_emit.
//
// Input side is a queue: a number transfers when push is high and full low.
// Only the low VALUE_BITS bits of value are used. Output side is a queue:
// while empty is low, digit_char holds the oldest ASCII digit and last marks
// the least significant digit of a number; it transfers when pop is high.
// Digits come most significant first, no leading zeros; zero gives one '0'.
// A number needing more than MAX_DIGITS digits gives its low MAX_DIGITS
// digits, leading zeros kept.
// A number passes through the input queue, the shift-add-3 converter and a
// handoff to the output stage; its digits then go out one per cycle while
// pop is high. The converter works on the next number while the output
// stage sends the previous one, so in steady state the converter loop and
// the single-digit output stage limit the throughput.
// Reset clears the queues and the sequencers; nothing is kept between
// numbers. When pop stays low the output register holds its digit, the
// back end stops, then the converter, then the input queue raises full.
`timescale 1ns / 1ps

module binary_to_decimal_ascii #(
    parameter int VALUE_BITS = b2da_pkg::VALUE_BITS_DEF,
    parameter int MAX_DIGITS = b2da_pkg::MAX_DIGITS_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic [b2da_pkg::IN_BITS-1:0]    value,
    input  logic                            push,
    output logic                            full,
    output logic [b2da_pkg::CHAR_BITS-1:0]  digit_char,
    output logic                            last,
    output logic                            empty,
    input  logic                            pop
);

    localparam int BCD_W = MAX_DIGITS * b2da_pkg::DIGIT_BITS;
    localparam int CNT_W = $clog2(MAX_DIGITS + 1);

    logic                  q_valid;
    logic [VALUE_BITS-1:0] q_value;
    logic                  q_take;
    logic                  c_valid;
    logic [BCD_W-1:0]      c_digits;
    logic [CNT_W-1:0]      c_count;
    logic                  c_ready;

    b2da_front #(
        .VALUE_BITS (VALUE_BITS)
    ) u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .value   (value),
        .push    (push),
        .full    (full),
        .q_valid (q_valid),
        .q_value (q_value),
        .q_take  (q_take)
    );

    b2da_conv #(
        .VALUE_BITS (VALUE_BITS),
        .MAX_DIGITS (MAX_DIGITS)
    ) u_conv (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (q_valid),
        .in_value   (q_value),
        .in_take    (q_take),
        .out_valid  (c_valid),
        .out_digits (c_digits),
        .out_count  (c_count),
        .out_ready  (c_ready)
    );

    b2da_emit #(
        .MAX_DIGITS (MAX_DIGITS)
    ) u_emit (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (c_valid),
        .in_digits  (c_digits),
        .in_count   (c_count),
        .in_ready   (c_ready),
        .digit_char (digit_char),
        .last       (last),
        .empty      (empty),
        .pop        (pop)
    );

endmodule

/* tb/tb_binary_to_decimal_ascii.sv */
// Self-checking testbench for binary_to_decimal_ascii: numbers go in through the push/full side,
// and a scoreboard predicts their ASCII digit stream and checks each pop transfer against it.
// Depends on b2da_pkg and rtl/binary_to_decimal_ascii.sv.
`timescale 1ns / 1ps

typedef struct packed {
    logic [b2da_pkg::CHAR_BITS-1:0] char_code;
    logic                           is_last;
} digit_rec_t;

class digit_scoreboard;
    localparam int VALUE_BITS = b2da_pkg::VALUE_BITS_DEF;
    localparam int MAX_DIGITS = b2da_pkg::MAX_DIGITS_DEF;

    digit_rec_t expected_digits[$];
    int         numbers_seen;
    int         digits_checked;
    int         errors;

    function void note_number(logic [b2da_pkg::IN_BITS-1:0] v);
        logic [63:0]                     mask;
        logic [63:0]                     rest;
        logic [b2da_pkg::DIGIT_BITS-1:0] digits[$];
        digit_rec_t                      rec;
        int                              n;
        mask = (VALUE_BITS >= 64) ? '1 : ((64'd1 << VALUE_BITS) - 64'd1);
        rest = {32'd0, v} & mask;
        do
        begin
            digits.push_front(b2da_pkg::DIGIT_BITS'(rest % 64'd10));
            rest = rest / 64'd10;
        end
        while (rest != 0 && digits.size() < MAX_DIGITS);
        n = digits.size();
        for (int k = 0; k < n; k++)
        begin
            rec.char_code = b2da_pkg::ASCII_ZERO + b2da_pkg::CHAR_BITS'(digits[k]);
            rec.is_last   = (k == n - 1);
            expected_digits.push_back(rec);
        end
        numbers_seen++;
    endfunction

    function void check_digit(logic [b2da_pkg::CHAR_BITS-1:0] char_code, logic is_last);
        digit_rec_t exp_rec;
        if (expected_digits.size() == 0)
        begin
            $display("%0t: unexpected digit transfer, char %0d last %b", $time, char_code,
                     is_last);
            errors++;
            return;
        end
        exp_rec = expected_digits.pop_front();
        digits_checked++;
        if (char_code !== exp_rec.char_code)
        begin
            $display("%0t: digit_char mismatch, expected %0d actual %0d", $time,
                     exp_rec.char_code, char_code);
            errors++;
        end
        if (is_last !== exp_rec.is_last)
        begin
            $display("%0t: last mismatch, expected %b actual %b", $time, exp_rec.is_last,
                     is_last);
            errors++;
        end
    endfunction

    function int pending();
        return expected_digits.size();
    endfunction
endclass

module tb_binary_to_decimal_ascii;

    localparam int RANDOM_ITEMS = 350;
    localparam int HOLD_CYCLES  = 300;

    logic                                clk;
    logic                                rst_n;
    logic [b2da_pkg::IN_BITS-1:0]        value;
    logic                                push;
    logic                                full;
    logic [b2da_pkg::CHAR_BITS-1:0]      digit_char;
    logic                                last;
    logic                                empty;
    logic                                pop;

    digit_scoreboard sb;
    bit              hold_req;
    int              full_stalls;
    int              holds_done;

    binary_to_decimal_ascii i_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .value      (value),
        .push       (push),
        .full       (full),
        .digit_char (digit_char),
        .last       (last),
        .empty      (empty),
        .pop        (pop)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #2_000_000;
        $display("end of test: mismatches");
        $finish;
    end

    function automatic logic [63:0] pow10(int k);
        logic [63:0] p;
        p = 64'd1;
        for (int i = 0; i < k; i++)
        begin
            p = p * 64'd10;
        end
        return p;
    endfunction

    // Mix of full-range, fixed-length, small and near-boundary numbers.
    function automatic logic [31:0] pick_value();
        logic [63:0] lo;
        logic [63:0] hi;
        logic [63:0] v;
        int          nd;
        case ($urandom_range(0, 3))
            0: v = 64'($urandom());
            1:
            begin
                nd = $urandom_range(1, b2da_pkg::MAX_DIGITS_DEF);
                lo = (nd == 1) ? 64'd0 : pow10(nd - 1);
                hi = pow10(nd) - 64'd1;
                if (hi > 64'hFFFF_FFFF)
                begin
                    hi = 64'hFFFF_FFFF;
                end
                v = 64'($urandom_range(hi[31:0], lo[31:0]));
            end
            2: v = 64'($urandom_range(999, 0));
            default:
            begin
                nd = $urandom_range(1, 9);
                v  = pow10(nd) + 64'($urandom_range(4, 0)) - 64'd2;
                if ($urandom_range(0, 4) == 0)
                begin
                    v = 64'hFFFF_FFFF - 64'($urandom_range(3, 0));
                end
            end
        endcase
        return v[31:0];
    endfunction

    // Called at a falling edge; returns at the falling edge after the transfer.
    task automatic send_number(input logic [31:0] v);
        value <= v;
        push  <= 1'b1;
        do
        begin
            @(posedge clk);
        end
        while (full !== 1'b0);
        sb.note_number(v);
        @(negedge clk);
    endtask

    task automatic idle_cycles(input int n);
        push  <= 1'b0;
        value <= $urandom();
        repeat (n) @(negedge clk);
    endtask

    task automatic drain_wait();
        idle_cycles(1);
        while (sb.pending() != 0)
        begin
            @(negedge clk);
        end
    endtask

    // Receiver: stall pattern is chosen at random from four modes; long hold-off on request.
    initial
    begin
        int mode;
        int cyc;
        pop = 1'b0;
        mode = 0;
        cyc = 0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(negedge clk);
            if (hold_req)
            begin
                pop <= 1'b0;
                for (int i = 0; i < HOLD_CYCLES; i++)
                begin
                    @(negedge clk);
                end
                hold_req = 1'b0;
                holds_done++;
                pop <= 1'b1;
            end
            else
            begin
                if (cyc % 64 == 0)
                begin
                    mode = $urandom_range(0, 3);
                end
                case (mode)
                    0: pop <= 1'b1;
                    1: pop <= 1'($urandom_range(0, 1));
                    2: pop <= (cyc % 4 != 3);
                    default: pop <= ($urandom_range(0, 3) == 0);
                endcase
            end
            cyc++;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && pop && empty === 1'b0)
        begin
            sb.check_digit(digit_char, last);
        end
        if (rst_n && push && full === 1'b1)
        begin
            full_stalls++;
        end
    end

    initial
    begin
        logic [31:0] directed[$];
        int          burst_left;
        sb = new();
        hold_req = 1'b0;
        full_stalls = 0;
        holds_done = 0;
        rst_n = 1'b0;
        push = 1'b0;
        value = '0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        directed = '{32'd0, 32'd1, 32'd7, 32'd9, 32'd10, 32'd11, 32'd99, 32'd100, 32'd101,
                     32'd999, 32'd1000, 32'd65535, 32'd65536, 32'd99999999, 32'd100000000,
                     32'd999999999, 32'd1000000000, 32'd1234567890, 32'd2147483647,
                     32'd2147483648, 32'h5555_5555, 32'hAAAA_AAAA, 32'd4294967294,
                     32'd4294967295};
        foreach (directed[i])
        begin
            send_number(directed[i]);
        end
        drain_wait();

        burst_left = 0;
        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            if (n == 100)
            begin
                hold_req = 1'b1;
            end
            if (n == 220)
            begin
                drain_wait();
            end
            if (burst_left == 0)
            begin
                burst_left = $urandom_range(1, 20);
                if ($urandom_range(0, 3) != 0)
                begin
                    idle_cycles($urandom_range(1, 12));
                end
            end
            send_number(pick_value());
            burst_left--;
        end

        push <= 1'b0;
        while (sb.pending() != 0)
        begin
            @(negedge clk);
        end
        repeat (40) @(negedge clk);

        $display("converted %0d numbers, checked %0d digits", sb.numbers_seen,
                 sb.digits_checked);
        $display("input held off for %0d cycles, %0d long output stall(s)", full_stalls,
                 holds_done);
        if (sb.errors == 0)
        begin
            $display("end of test: clean");
        end
        else
        begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule

/* binary_to_decimal_ascii.f */
rtl/b2da_pkg.sv
rtl/b2da_front.sv
rtl/b2da_conv.sv
rtl/b2da_emit.sv
rtl/binary_to_decimal_ascii.sv
tb/tb_binary_to_decimal_ascii.sv
